>>> src/iff_chunk_deframer_defines.svh
// ---------------------------------------------------------------------------
// iff_chunk_deframer assertion macros
// Assertion helpers; clock i_clk, reset i_rst_n in the using module.
// ---------------------------------------------------------------------------
`ifndef IFF_CHUNK_DEFRAMER_DEFINES_SVH
`define IFF_CHUNK_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define ICD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ICD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/icd_pkg.sv
// ---------------------------------------------------------------------------
// icd_pkg
// Types and constants of the IFF chunk deframer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package icd_pkg;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_HEADER_BAD,
        PH_CHUNK_HDR,
        PH_DATA,
        PH_PAD,
        PH_TAIL,
        PH_IDLE
    } t_phase;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic [2:0] ERR_TOO_SMALL  = 3'd0;
    localparam logic [2:0] ERR_BAD_MAGIC  = 3'd1;
    localparam logic [2:0] ERR_TRUNCATED  = 3'd2;
    localparam logic [2:0] ERR_BAD_TYPE   = 3'd3;
    localparam logic [2:0] ERR_CHUNK_PAST = 3'd4;

    localparam logic [31:0] MAGIC_FOR1 = 32'h464F_5231;
    localparam logic [31:0] TYPE_BEAM  = 32'h4245_414D;

    // byte offsets within the 12-byte form header
    localparam logic [32:0] HDR_MAGIC_LAST = 33'd3;
    localparam logic [32:0] HDR_SIZE_LAST  = 33'd7;
    localparam logic [32:0] HDR_TYPE_LAST  = 33'd11;

    // byte offsets within an 8-byte chunk header
    localparam logic [2:0] CHDR_TAG_LAST = 3'd3;
    localparam logic [2:0] CHDR_LEN_LAST = 3'd7;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] chunk_tag;
        logic [31:0] chunk_length;
        logic [7:0]  payload_byte;
        logic        chunk_final;
        logic [2:0]  error_code;
        logic        run_last;
    } t_result;

    typedef struct packed {
        t_result [1:0] res;
        logic [1:0]    count;
    } t_step_out;

    function automatic t_result mk_result(
        input logic [1:0]  kind,
        input logic [31:0] tag,
        input logic [31:0] len,
        input logic [7:0]  pay,
        input logic        fin,
        input logic [2:0]  err
    );
        t_result r;
        r.kind         = kind;
        r.chunk_tag    = tag;
        r.chunk_length = len;
        r.payload_byte = pay;
        r.chunk_final  = fin;
        r.error_code   = err;
        r.run_last     = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/icd_if.sv
// ---------------------------------------------------------------------------
// icd_in_if / icd_out_if
// Valid/ready channels of the IFF chunk deframer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface icd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_file;

    modport source (output valid, in_byte, end_of_file, input ready);
    modport sink   (input valid, in_byte, end_of_file, output ready);
endinterface

interface icd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] chunk_tag;
    logic [31:0] chunk_length;
    logic [7:0]  payload_byte;
    logic        chunk_final;
    logic [2:0]  error_code;
    logic        run_last;

    modport source (output valid, kind, chunk_tag, chunk_length, payload_byte,
                    chunk_final, error_code, run_last, input ready);
    modport sink   (input valid, kind, chunk_tag, chunk_length, payload_byte,
                    chunk_final, error_code, run_last, output ready);
endinterface

`default_nettype wire

>>> src/icd_step.sv
// ---------------------------------------------------------------------------
// icd_step
// Parser state and the per-byte update; yields up to two results per byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "iff_chunk_deframer_defines.svh"

module icd_step
    import icd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_go,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_eof,
    output t_step_out       o_step
);

    t_phase      r_phase, n_phase;
    logic [32:0] r_pos, n_pos;
    logic [32:0] r_end, n_end;
    logic [31:0] r_shift, n_shift;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_left, n_left;
    logic [1:0]  r_pad, n_pad;
    logic [2:0]  r_hcnt, n_hcnt;

    logic [31:0] shift_in;
    logic [32:0] pos1;
    logic        c_done;
    logic        c_tail;
    logic        c_past;

    t_result     v_res [2];
    logic [1:0]  v_n;
    logic        v_bnd;
    logic        v_after;

    assign shift_in = {r_shift[23:0], i_byte};
    assign pos1     = r_pos + 33'd1;
    assign c_done   = pos1 >= r_end;
    assign c_tail   = ({1'b0, pos1} + 34'd8) > {1'b0, r_end};
    assign c_past   = ({1'b0, pos1} + {2'b00, shift_in}) > {1'b0, r_end};

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_end    = r_end;
        n_shift  = r_shift;
        n_tag    = r_tag;
        n_left   = r_left;
        n_pad    = r_pad;
        n_hcnt   = r_hcnt;
        v_res[0] = mk_result(KIND_START, '0, '0, '0, 1'b0, '0);
        v_res[1] = mk_result(KIND_START, '0, '0, '0, 1'b0, '0);
        v_n      = 2'd0;
        v_bnd    = 1'b0;
        v_after  = 1'b0;

        case (r_phase)
            PH_HEADER, PH_HEADER_BAD: begin
                n_shift = shift_in;
                n_pos   = pos1;
                if (r_pos == HDR_MAGIC_LAST && shift_in != MAGIC_FOR1) begin
                    n_phase = PH_HEADER_BAD;
                end
                if (r_pos == HDR_SIZE_LAST) begin
                    n_end = {1'b0, shift_in} + 33'd8;
                end
                if (r_pos >= HDR_TYPE_LAST) begin
                    if (n_phase == PH_HEADER_BAD) begin
                        v_res[v_n[0]] = mk_result(KIND_ERROR, '0, '0, '0, 1'b0,
                                                  ERR_BAD_MAGIC);
                        v_n     = v_n + 2'd1;
                        n_phase = PH_IDLE;
                    end else if (shift_in != TYPE_BEAM) begin
                        v_res[v_n[0]] = mk_result(KIND_ERROR, '0, '0, '0, 1'b0,
                                                  ERR_BAD_TYPE);
                        v_n     = v_n + 2'd1;
                        n_phase = PH_IDLE;
                    end else begin
                        v_bnd = 1'b1;
                    end
                end
            end
            PH_CHUNK_HDR: begin
                n_shift = shift_in;
                n_pos   = pos1;
                if (r_hcnt == CHDR_TAG_LAST) begin
                    n_tag = shift_in;
                end
                if (r_hcnt == CHDR_LEN_LAST) begin
                    if (c_past) begin
                        v_res[v_n[0]] = mk_result(KIND_ERROR, '0, '0, '0, 1'b0,
                                                  ERR_CHUNK_PAST);
                        v_n     = v_n + 2'd1;
                        n_phase = PH_IDLE;
                    end else begin
                        v_res[v_n[0]] = mk_result(KIND_START, r_tag, shift_in, '0,
                                                  1'b0, '0);
                        v_n    = v_n + 2'd1;
                        n_left = shift_in;
                        n_pad  = 2'd0 - shift_in[1:0];
                        if (shift_in == 32'd0) begin
                            v_after = 1'b1;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end else begin
                    n_hcnt = r_hcnt + 3'd1;
                end
            end
            PH_DATA: begin
                n_pos  = pos1;
                n_left = (r_left != 32'd0) ? r_left - 32'd1 : 32'd0;
                v_res[v_n[0]] = mk_result(KIND_DATA, '0, '0, i_byte,
                                          n_left == 32'd0, '0);
                v_n = v_n + 2'd1;
                if (n_left == 32'd0) begin
                    v_after = 1'b1;
                end
            end
            PH_PAD: begin
                n_pos = pos1;
                n_pad = r_pad - 2'd1;
                if (n_pad == 2'd0 || c_done) begin
                    v_bnd = 1'b1;
                end
            end
            PH_TAIL: begin
                n_pos = pos1;
                if (c_done) begin
                    v_res[v_n[0]] = mk_result(KIND_DONE, '0, '0, '0, 1'b0, '0);
                    v_n     = v_n + 2'd1;
                    n_phase = PH_IDLE;
                end
            end
            default: begin
            end
        endcase

        // end of chunk data: pad first, unless the form is already used up
        if (v_after) begin
            if (n_pad != 2'd0 && !c_done) begin
                n_phase = PH_PAD;
            end else begin
                v_bnd = 1'b1;
            end
        end

        // chunk boundary: form done, short tail, or next chunk header
        if (v_bnd) begin
            if (c_done) begin
                v_res[v_n[0]] = mk_result(KIND_DONE, '0, '0, '0, 1'b0, '0);
                v_n     = v_n + 2'd1;
                n_phase = PH_IDLE;
            end else if (c_tail) begin
                n_phase = PH_TAIL;
            end else begin
                n_phase = PH_CHUNK_HDR;
                n_hcnt  = 3'd0;
            end
        end

        if (i_eof) begin
            if (n_phase == PH_HEADER || n_phase == PH_HEADER_BAD) begin
                v_res[v_n[0]] = mk_result(KIND_ERROR, '0, '0, '0, 1'b0, ERR_TOO_SMALL);
                v_n = v_n + 2'd1;
            end else if (n_phase != PH_IDLE) begin
                v_res[v_n[0]] = mk_result(KIND_ERROR, '0, '0, '0, 1'b0, ERR_TRUNCATED);
                v_n = v_n + 2'd1;
            end
            n_phase = PH_HEADER;
            n_pos   = '0;
            n_end   = '0;
            n_shift = '0;
            n_tag   = '0;
            n_left  = '0;
            n_pad   = '0;
            n_hcnt  = '0;
        end

        if (v_n == 2'd1) begin
            v_res[0].run_last = 1'b1;
        end else if (v_n == 2'd2) begin
            v_res[1].run_last = 1'b1;
        end

        o_step.res[0] = v_res[0];
        o_step.res[1] = v_res[1];
        o_step.count  = v_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;
            r_end   <= '0;
            r_shift <= '0;
            r_tag   <= '0;
            r_left  <= '0;
            r_pad   <= '0;
            r_hcnt  <= '0;
        end else if (i_go) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_end   <= n_end;
            r_shift <= n_shift;
            r_tag   <= n_tag;
            r_left  <= n_left;
            r_pad   <= n_pad;
            r_hcnt  <= n_hcnt;
        end
    end

    `ICD_ASSERT_SAME(a_last_single, o_step.count == 2'd1,
        o_step.res[0].run_last, "run_last missing on single result")
    `ICD_ASSERT_SAME(a_last_pair, o_step.count == 2'd2,
        !o_step.res[0].run_last && o_step.res[1].run_last, "run_last misplaced on pair")
    `ICD_ASSERT_SAME(a_idle_quiet, i_go && r_phase == PH_IDLE && !i_eof,
        o_step.count == 2'd0, "result produced after form finished")
    `ICD_ASSERT_SAME(a_data_phase,
        o_step.count != 2'd0 && o_step.res[0].kind == KIND_DATA,
        r_phase == PH_DATA, "data result outside chunk data")
    `ICD_ASSERT_NEXT(a_eof_rewind, i_go && i_eof,
        r_phase == PH_HEADER && r_pos == 33'd0, "state not rewound after end of file")

endmodule

`default_nettype wire

>>> src/icd_outbuf.sv
// ---------------------------------------------------------------------------
// icd_outbuf
// Two-entry result register; loads a byte's results, drains one per ready cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module icd_outbuf
    import icd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_load,
    input  wire t_step_out i_step,
    input  wire logic      i_out_ready,
    output logic           o_take,
    output logic           o_valid,
    output t_result        o_head
);

    logic [1:0] r_cnt, n_cnt;
    t_result    r_res0, n_res0;
    t_result    r_res1, n_res1;

    // room for a new pair once the last held item leaves
    assign o_take  = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_out_ready);
    assign o_valid = r_cnt != 2'd0;
    assign o_head  = r_res0;

    always_comb begin
        n_cnt  = r_cnt;
        n_res0 = r_res0;
        n_res1 = r_res1;
        if (i_load) begin
            n_cnt  = i_step.count;
            n_res0 = i_step.res[0];
            n_res1 = i_step.res[1];
        end else if (r_cnt == 2'd2 && i_out_ready) begin
            n_cnt  = 2'd1;
            n_res0 = r_res1;
        end else if (r_cnt == 2'd1 && i_out_ready) begin
            n_cnt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res0 <= n_res0;
        r_res1 <= n_res1;
    end

endmodule

`default_nettype wire

>>> src/iff_chunk_deframer.sv
// ---------------------------------------------------------------------------
// iff_chunk_deframer
// Streaming parser for a FOR1/BEAM IFF container, one file byte per item.
// ---------------------------------------------------------------------------
// Feed the file one byte per input item, end_of_file high on its last byte.
// The block checks the 12-byte form header (magic, big-endian size, type),
// then walks the chunks: each chunk gives a chunk-start item with tag and
// length, then one data item per byte (chunk_final on the last), pad bytes
// and trailing bytes are dropped, and a form-complete item closes the form.
// Errors come out as kind 3 items; a truncation error can follow chunks
// already delivered. run_last marks the last result of each input byte, and
// end_of_file rewinds the parser for the next file. Rate: one input byte per
// cycle while results are taken; a byte that yields two results (for example
// last data byte plus form complete, or a result plus an end-of-file error)
// fills both entries of the result register, so the input stalls until the
// first result has been taken. An accepted byte goes through the input
// register, then the parse step into the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iff_chunk_deframer
    import icd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    icd_in_if.sink     i_in,
    icd_out_if.source  o_out
);

    // input register
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eof;

    logic       in_accept;
    logic       buf_take;
    logic       step_go;
    t_step_out  step_out;
    t_result    head;
    logic       head_valid;

    // parse step fires when a byte is held and the result register has room
    assign step_go    = r_in_valid && buf_take;
    assign i_in.ready = !r_in_valid || step_go;
    assign in_accept  = i_in.valid && i_in.ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (step_go) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_in.in_byte;
            r_in_eof  <= i_in.end_of_file;
        end
    end

    icd_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (step_go),
        .i_byte  (r_in_byte),
        .i_eof   (r_in_eof),
        .o_step  (step_out)
    );

    icd_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step_go),
        .i_step      (step_out),
        .i_out_ready (o_out.ready),
        .o_take      (buf_take),
        .o_valid     (head_valid),
        .o_head      (head)
    );

    assign o_out.valid        = head_valid;
    assign o_out.kind         = head.kind;
    assign o_out.chunk_tag    = head.chunk_tag;
    assign o_out.chunk_length = head.chunk_length;
    assign o_out.payload_byte = head.payload_byte;
    assign o_out.chunk_final  = head.chunk_final;
    assign o_out.error_code   = head.error_code;
    assign o_out.run_last     = head.run_last;

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the FOR1/BEAM chunk deframer.
// ---------------------------------------------------------------------------
// Whole files are built byte by byte and streamed into the block, with the
// end-of-file flag on the last byte. A table of hand-picked files comes
// first: short files, bad magic, bad form type, tiny forms, truncation, a
// chunk running past the form, pad cut off by the form end, a partial
// trailing header. Random files follow, mostly well-formed with random
// chunk layouts, the rest damaged in one way or another. A parser model in
// this bench predicts the results of untyped files, and the result stream
// is checked field by field in order. Both sides idle at random, the receiver
// holds off for a long stretch once, the sender pauses until the block drains.
// ---------------------------------------------------------------------------

module tb_top;
    import icd_pkg::*;

    localparam int          HALF_PERIOD      = 6;
    localparam int          RESET_CYCLES     = 12;
    localparam int          TOTAL_ITEMS      = 400;
    localparam int          MIN_RANDOM_ITEMS = 120;
    localparam int          LONG_STALL       = 300;
    localparam int          DRAIN_CYCLES     = 8;
    localparam int          MAX_REPORTS      = 100;
    localparam logic [2:0]  ERR_NONE         = 3'd0;

    // knobs of one generated file
    typedef struct {
        logic [31:0] magic;
        logic [31:0] form_type;
        bit          size_forced;     // use size_value instead of the real size
        logic [31:0] size_value;
        int          size_delta;      // added to the real size
        int          n_chunks;
        int          max_len;
        bit          last_len_forced;
        logic [31:0] last_len;
        int          tail_bytes;      // partial header bytes inside the form
        int          junk_bytes;      // bytes after the form
        int          keep;            // cut the file to this many bytes, 0: keep all
        bit          typed;           // expected result given in the row
        logic [1:0]  exp_kind;
        logic [2:0]  exp_err;
    } t_file_spec;

    logic i_clk = 1'b0;
    logic i_rst_n;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    icd_in_if  in_ch ();
    icd_out_if out_ch ();

    iff_chunk_deframer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Directed files. Columns: magic, type, size forced, size value, size delta,
    // chunks, max len, last len forced, last len, tail, junk, keep,
    // typed, kind, error.
    t_file_spec dir_tbl [17] = '{
        // one byte only
        '{MAGIC_FOR1, TYPE_BEAM, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
          1, KIND_ERROR, ERR_TOO_SMALL},
        // eleven bytes, bad magic too: too-small wins
        '{32'hFFFF_FFFF, TYPE_BEAM, 0, 0, 0, 0, 0, 0, 0, 0, 0, 11,
          1, KIND_ERROR, ERR_TOO_SMALL},
        '{32'hFFFF_FFFF, TYPE_BEAM, 0, 0, 0, 0, 0, 0, 0, 0, 3, 0,
          1, KIND_ERROR, ERR_BAD_MAGIC},
        '{32'h0000_0000, TYPE_BEAM, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
          1, KIND_ERROR, ERR_BAD_MAGIC},
        // bad type on a form far longer than the file
        '{MAGIC_FOR1, 32'h0000_0000, 1, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0,
          1, KIND_ERROR, ERR_BAD_TYPE},
        '{MAGIC_FOR1, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0, 2, 0,
          1, KIND_ERROR, ERR_BAD_TYPE},
        // form size below four
        '{MAGIC_FOR1, TYPE_BEAM, 1, 0, 0, 0, 0, 0, 0, 0, 2, 0,
          1, KIND_DONE, ERR_NONE},
        // empty form, size exactly four
        '{MAGIC_FOR1, TYPE_BEAM, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
          1, KIND_DONE, ERR_NONE},
        // largest size, file ends right after the header
        '{MAGIC_FOR1, TYPE_BEAM, 1, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0,
          1, KIND_ERROR, ERR_TRUNCATED},
        // the rest go through the parser model
        '{MAGIC_FOR1, TYPE_BEAM, 0, 0, 0, 4, 7, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MAGIC_FOR1, TYPE_BEAM, 0, 0, 0, 2, 0, 0, 0, 0, 1, 0, 0, 0, 0},
        // last chunk one byte past the form
        '{MAGIC_FOR1, TYPE_BEAM, 0, 0, -1, 2, 6, 1, 8, 0, 0, 0, 0, 0, 0},
        '{MAGIC_FOR1, TYPE_BEAM, 0, 0, 0, 1, 0, 1, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0},
        // truncated inside the chunks
        '{MAGIC_FOR1, TYPE_BEAM, 0, 0, 0, 2, 9, 1, 9, 0, 0, 30, 0, 0, 0},
        // truncated inside a chunk header
        '{MAGIC_FOR1, TYPE_BEAM, 0, 0, 0, 1, 5, 0, 0, 0, 0, 16, 0, 0, 0},
        // partial chunk header at the form end
        '{MAGIC_FOR1, TYPE_BEAM, 0, 0, 0, 1, 5, 0, 0, 5, 2, 0, 0, 0, 0},
        // form ends inside the pad
        '{MAGIC_FOR1, TYPE_BEAM, 0, 0, -2, 1, 0, 1, 5, 0, 0, 0, 0, 0, 0}
    };

    // parser model state
    t_phase      prs_phase;
    logic [32:0] prs_pos;
    logic [32:0] prs_end;
    logic [31:0] prs_shift;
    logic [31:0] prs_tag;
    logic [31:0] prs_left;
    logic [1:0]  prs_pad;
    logic [2:0]  prs_hcnt;

    t_result     step_res [$];         // results of the byte just parsed
    t_result     pending_results [$];  // results still owed by the block
    logic [7:0]  file_q [$];

    int tx_idle_pct = 29;
    int rx_idle_pct = 81;
    bit stall_req   = 1'b0;

    int fail_count    = 0;
    int files_fed     = 0;
    int bytes_fed     = 0;
    int parsed_bytes  = 0;
    int results_seen  = 0;
    int kinds_seen [4] = '{0, 0, 0, 0};

    // random part pacing
    int rand_budget = 0;
    int rand_start  = 0;
    int regime      = 0;

    // ---------------- parser model ----------------

    function automatic void reset_parser();
        prs_phase = PH_HEADER;
        prs_pos   = '0;
        prs_end   = '0;
        prs_shift = '0;
        prs_tag   = '0;
        prs_left  = '0;
        prs_pad   = '0;
        prs_hcnt  = '0;
    endfunction

    function automatic void add_result(logic [1:0] kind, logic [31:0] tag, logic [31:0] len,
                                       logic [7:0] pay, logic fin, logic [2:0] err);
        t_result r;
        r.kind         = kind;
        r.chunk_tag    = tag;
        r.chunk_length = len;
        r.payload_byte = pay;
        r.chunk_final  = fin;
        r.error_code   = err;
        r.run_last     = 1'b0;
        step_res = {step_res, r};
    endfunction

    // at a chunk boundary: form done, partial header left, or a new header
    function automatic void next_chunk_or_end();
        if (prs_pos >= prs_end) begin
            add_result(KIND_DONE, '0, '0, '0, 1'b0, ERR_NONE);
            prs_phase = PH_IDLE;
        end else if ({1'b0, prs_pos} + 34'd8 > {1'b0, prs_end}) begin
            prs_phase = PH_TAIL;
        end else begin
            prs_phase = PH_CHUNK_HDR;
            prs_hcnt  = '0;
        end
    endfunction

    function automatic void finish_chunk();
        if (prs_pad != 2'd0 && prs_pos < prs_end)
            prs_phase = PH_PAD;
        else
            next_chunk_or_end();
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic eof);
        logic [32:0] idx;
        logic [31:0] len;
        t_result     last_r;
        step_res.delete();
        case (prs_phase)
            PH_HEADER, PH_HEADER_BAD: begin
                idx       = prs_pos;
                prs_shift = {prs_shift[23:0], b};
                prs_pos   = prs_pos + 33'd1;
                if (idx == HDR_MAGIC_LAST && prs_shift != MAGIC_FOR1)
                    prs_phase = PH_HEADER_BAD;
                if (idx == HDR_SIZE_LAST)
                    prs_end = {1'b0, prs_shift} + 33'd8;
                if (idx == HDR_TYPE_LAST) begin
                    if (prs_phase == PH_HEADER_BAD) begin
                        add_result(KIND_ERROR, '0, '0, '0, 1'b0, ERR_BAD_MAGIC);
                        prs_phase = PH_IDLE;
                    end else if (prs_shift != TYPE_BEAM) begin
                        add_result(KIND_ERROR, '0, '0, '0, 1'b0, ERR_BAD_TYPE);
                        prs_phase = PH_IDLE;
                    end else begin
                        next_chunk_or_end();
                    end
                end
            end
            PH_CHUNK_HDR: begin
                prs_shift = {prs_shift[23:0], b};
                prs_pos   = prs_pos + 33'd1;
                if (prs_hcnt == CHDR_TAG_LAST)
                    prs_tag = prs_shift;
                if (prs_hcnt >= CHDR_LEN_LAST) begin
                    len = prs_shift;
                    if ({1'b0, prs_pos} + {2'b0, len} > {1'b0, prs_end}) begin
                        add_result(KIND_ERROR, '0, '0, '0, 1'b0, ERR_CHUNK_PAST);
                        prs_phase = PH_IDLE;
                    end else begin
                        add_result(KIND_START, prs_tag, len, '0, 1'b0, ERR_NONE);
                        prs_left = len;
                        prs_pad  = 2'd0 - len[1:0];
                        if (len == '0)
                            finish_chunk();
                        else
                            prs_phase = PH_DATA;
                    end
                end else begin
                    prs_hcnt = prs_hcnt + 3'd1;
                end
            end
            PH_DATA: begin
                prs_pos = prs_pos + 33'd1;
                if (prs_left != '0)
                    prs_left = prs_left - 32'd1;
                add_result(KIND_DATA, '0, '0, b, prs_left == '0, ERR_NONE);
                if (prs_left == '0)
                    finish_chunk();
            end
            PH_PAD: begin
                prs_pos = prs_pos + 33'd1;
                prs_pad = prs_pad - 2'd1;
                if (prs_pad == 2'd0 || prs_pos >= prs_end)
                    next_chunk_or_end();
            end
            PH_TAIL: begin
                prs_pos = prs_pos + 33'd1;
                if (prs_pos >= prs_end) begin
                    add_result(KIND_DONE, '0, '0, '0, 1'b0, ERR_NONE);
                    prs_phase = PH_IDLE;
                end
            end
            default: ;
        endcase

        if (eof) begin
            if (prs_phase == PH_HEADER || prs_phase == PH_HEADER_BAD)
                add_result(KIND_ERROR, '0, '0, '0, 1'b0, ERR_TOO_SMALL);
            else if (prs_phase != PH_IDLE)
                add_result(KIND_ERROR, '0, '0, '0, 1'b0, ERR_TRUNCATED);
            reset_parser();
        end

        if (step_res.size() != 0) begin
            last_r          = step_res[$];
            last_r.run_last = 1'b1;
            step_res[step_res.size() - 1] = last_r;
        end
    endfunction

    // ---------------- file generation ----------------

    function automatic void push_word(logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            file_q = {file_q, w[8*i +: 8]};
    endfunction

    function automatic void build_file(t_file_spec s);
        logic [31:0] len;
        logic [31:0] size;
        logic [1:0]  pad_n;
        int          n_data;
        file_q.delete();
        push_word(s.magic);
        push_word('0);  // size, patched below
        push_word(s.form_type);
        for (int c = 0; c < s.n_chunks; c++) begin
            if (c == s.n_chunks - 1 && s.last_len_forced)
                len = s.last_len;
            else
                len = $urandom_range(s.max_len);
            push_word($urandom());
            push_word(len);
            // huge lengths get a header only; the block must reject them anyway
            n_data = (len <= 32'd64) ? int'(len) : 0;
            pad_n  = 2'd0 - len[1:0];
            for (int i = 0; i < n_data; i++)
                file_q = {file_q, 8'($urandom())};
            if (n_data != 0)
                for (int i = 0; i < int'(pad_n); i++)
                    file_q = {file_q, 8'($urandom())};
        end
        for (int i = 0; i < s.tail_bytes; i++)
            file_q = {file_q, 8'($urandom())};
        size = s.size_forced ? s.size_value : 32'(file_q.size() - 8 + s.size_delta);
        for (int i = 0; i < 4; i++)
            file_q[4 + i] = size[8*(3-i) +: 8];
        for (int i = 0; i < s.junk_bytes; i++)
            file_q = {file_q, 8'($urandom())};
        if (s.keep > 0)
            while (file_q.size() > s.keep)
                void'(file_q.pop_back());
    endfunction

    // mostly well-formed files; the rest carry one kind of damage
    function automatic t_file_spec random_spec();
        t_file_spec s;
        s = '{MAGIC_FOR1, TYPE_BEAM, 0, 0, 0, 0, 9, 0, 0, 0, 0, 0, 0, 0, 0};
        s.n_chunks   = $urandom_range(4);
        s.max_len    = ($urandom_range(99) < 10) ? 40 : 9;
        s.junk_bytes = $urandom_range(2);
        if ($urandom_range(99) < 30) begin
            case ($urandom_range(7))
                0: s.magic     = s.magic ^ (32'd1 << $urandom_range(31));
                1: s.form_type = s.form_type ^ (32'd1 << $urandom_range(31));
                2: s.keep      = $urandom_range(40, 1);
                3: s.size_delta = int'($urandom_range(24)) - 12;
                4: s.tail_bytes = $urandom_range(7, 1);
                5: begin
                    s.size_forced = 1'b1;
                    s.size_value  = ($urandom_range(1)) ? $urandom() : $urandom_range(40);
                end
                6: begin
                    s.n_chunks        = $urandom_range(3, 1);
                    s.last_len_forced = 1'b1;
                    s.last_len        = $urandom();
                end
                default: begin
                    // plain noise
                    s.magic       = $urandom();
                    s.form_type   = $urandom();
                    s.size_forced = 1'b1;
                    s.size_value  = $urandom();
                    s.keep        = $urandom_range(20, 1);
                end
            endcase
        end
        return s;
    endfunction

    // ---------------- driving ----------------

    task automatic send_byte(input logic [7:0] b, input bit eof, input bit typed,
                             input bit counted);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.in_byte     <= b;
        in_ch.end_of_file <= eof;
        do @(posedge i_clk); while (!in_ch.ready);
        if (counted && prs_phase != PH_IDLE)
            parsed_bytes++;
        parse_byte(b, eof);
        // typed rows already queued their result from the table
        if (!typed)
            foreach (step_res[i])
                pending_results = {pending_results, step_res[i]};
        bytes_fed++;
    endtask

    task automatic feed_file(input t_file_spec s, input bit counted);
        t_result r;
        build_file(s);
        if (s.typed) begin
            r            = '0;
            r.kind       = s.exp_kind;
            r.error_code = s.exp_err;
            r.run_last   = 1'b1;
            pending_results = {pending_results, r};
        end
        foreach (file_q[i])
            send_byte(file_q[i], i == file_q.size() - 1, s.typed, counted);
        files_fed++;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // ---------------- result side ----------------

    function automatic void check_field(string fld, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, fld, want, got);
        end
    endfunction

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_req) begin
                stall_req  = 1'b0;
                stall_left = LONG_STALL - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.kind         = out_ch.kind;
            got.chunk_tag    = out_ch.chunk_tag;
            got.chunk_length = out_ch.chunk_length;
            got.payload_byte = out_ch.payload_byte;
            got.chunk_final  = out_ch.chunk_final;
            got.error_code   = out_ch.error_code;
            got.run_last     = out_ch.run_last;
            results_seen++;
            kinds_seen[got.kind]++;
            if (pending_results.size() == 0) begin
                fail_count++;
                $display("%0t: result with nothing expected, kind %0d", $time, got.kind);
            end else begin
                want = pending_results.pop_front();
                check_field("kind", want.kind, got.kind);
                check_field("chunk_tag", want.chunk_tag, got.chunk_tag);
                check_field("chunk_length", want.chunk_length, got.chunk_length);
                check_field("payload_byte", want.payload_byte, got.payload_byte);
                check_field("chunk_final", want.chunk_final, got.chunk_final);
                check_field("error_code", want.error_code, got.error_code);
                check_field("run_last", want.run_last, got.run_last);
            end
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.in_byte     <= '0;
        in_ch.end_of_file <= 1'b0;
        reset_parser();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // hand-picked files, sender sparse-ish, receiver mostly stalled
        foreach (dir_tbl[i])
            feed_file(dir_tbl[i], 1'b0);

        // random files fill up the byte budget, in three idling regimes;
        // each regime gets at least one file
        rand_budget = TOTAL_ITEMS - bytes_fed;
        if (rand_budget < MIN_RANDOM_ITEMS)
            rand_budget = MIN_RANDOM_ITEMS;
        rand_start = bytes_fed;
        while (bytes_fed - rand_start < rand_budget || regime != 2) begin
            if (regime == 0 && bytes_fed - rand_start >= rand_budget / 3) begin
                tx_idle_pct = 81;
                rx_idle_pct = 29;
                regime      = 1;
            end else if (regime == 1 && bytes_fed - rand_start >= 2 * rand_budget / 3) begin
                // sender waits for the block to drain, then a long receiver
                // hold-off with the sender pushing every cycle unless the block stalls
                in_ch.valid <= 1'b0;
                wait_drained();
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                stall_req   = 1'b1;
                regime      = 2;
            end
            feed_file(random_spec(), 1'b1);
        end

        in_ch.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Streamed %0d files, %0d bytes (%0d parsed in the random part)",
                 files_fed, bytes_fed, parsed_bytes);
        $display("Checked %0d results: %0d chunk starts, %0d data, %0d complete, %0d errors",
                 results_seen, kinds_seen[KIND_START], kinds_seen[KIND_DATA],
                 kinds_seen[KIND_DONE], kinds_seen[KIND_ERROR]);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> iff_chunk_deframer.f
+incdir+src
src/icd_pkg.sv
src/icd_if.sv
src/icd_step.sv
src/icd_outbuf.sv
src/iff_chunk_deframer.sv
bench/tb_top.sv
